[rtl/texel_to_rgba8_converter_defines.svh]
// Assertion macros for the texel to RGBA8 converter checker.
`ifndef TEXEL_TO_RGBA8_CONVERTER_DEFINES_SVH
`define TEXEL_TO_RGBA8_CONVERTER_DEFINES_SVH

// Checked only outside reset.
`define T2R_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define T2R_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/t2rgba_pkg.sv]
// Shared types, format codes and channel widening functions for the texel converter.
package t2rgba_pkg;

    typedef enum logic [3:0] {
        FMT_RGBA8       = 4'd0,
        FMT_BGRA8       = 4'd1,
        FMT_R8          = 4'd2,
        FMT_RG8         = 4'd3,
        FMT_R5G6B5      = 4'd4,
        FMT_A1R5G5B5    = 4'd5,
        FMT_A4R4G4B4    = 4'd6,
        FMT_RGB8_SIGNED = 4'd7,
        FMT_RAW32       = 4'd8,
        FMT_UNSUPPORTED = 4'd9
    } t2rgba_fmt_t;

    localparam logic [7:0] CHAN_MAX  = 8'hFF;
    localparam logic [7:0] SIGN_FLIP = 8'h80;

    typedef struct packed {
        logic [31:0] texel_word;
        logic        image_end;
    } t2rgba_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       unsupported;
        logic       image_end_out;
    } t2rgba_out_t;

    // floor(v*255/31) = 8v + floor(7v/31); the correction steps at v = 5,9,14,18,23,27,31
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [2:0] corr;
        corr = {2'b00, v >= 5'd5}  + {2'b00, v >= 5'd9}  + {2'b00, v >= 5'd14}
             + {2'b00, v >= 5'd18} + {2'b00, v >= 5'd23} + {2'b00, v >= 5'd27}
             + {2'b00, v >= 5'd31};
        return {v, 3'b000} + {5'b00000, corr};
    endfunction

    // floor(v*255/63) = 4v + floor(v/21)
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] corr;
        corr = {1'b0, v >= 6'd21} + {1'b0, v >= 6'd42} + {1'b0, v >= 6'd63};
        return {v, 2'b00} + {6'b000000, corr};
    endfunction

    // v*17 is nibble replication
    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

endpackage

[rtl/t2rgba_convert.sv]
// Combinational texel decode: one source word to one RGBA8 result.
module t2rgba_convert (
    input  logic [3:0]              source_format,
    input  t2rgba_pkg::t2rgba_in_t  texel,
    output t2rgba_pkg::t2rgba_out_t pixel
);
    import t2rgba_pkg::*;

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] px;

    assign b0 = texel.texel_word[7:0];
    assign b1 = texel.texel_word[15:8];
    assign b2 = texel.texel_word[23:16];
    assign b3 = texel.texel_word[31:24];
    assign px = texel.texel_word[15:0];

    always_comb begin
        pixel               = '0;
        pixel.image_end_out = texel.image_end;
        case (source_format)
            FMT_RGBA8, FMT_RAW32: begin
                pixel.red   = b0;
                pixel.green = b1;
                pixel.blue  = b2;
                pixel.alpha = b3;
            end
            FMT_BGRA8: begin
                pixel.red   = b2;
                pixel.green = b1;
                pixel.blue  = b0;
                pixel.alpha = b3;
            end
            FMT_R8: begin
                pixel.red   = b0;
                pixel.green = b0;
                pixel.blue  = b0;
                pixel.alpha = CHAN_MAX;
            end
            FMT_RG8: begin
                pixel.red   = b0;
                pixel.green = b1;
                pixel.alpha = CHAN_MAX;
            end
            FMT_R5G6B5: begin
                pixel.red   = widen5(px[15:11]);
                pixel.green = widen6(px[10:5]);
                pixel.blue  = widen5(px[4:0]);
                pixel.alpha = CHAN_MAX;
            end
            FMT_A1R5G5B5: begin
                pixel.red   = widen5(px[14:10]);
                pixel.green = widen5(px[9:5]);
                pixel.blue  = widen5(px[4:0]);
                pixel.alpha = px[15] ? CHAN_MAX : 8'h00;
            end
            FMT_A4R4G4B4: begin
                pixel.red   = widen4(px[11:8]);
                pixel.green = widen4(px[7:4]);
                pixel.blue  = widen4(px[3:0]);
                pixel.alpha = widen4(px[15:12]);
            end
            FMT_RGB8_SIGNED: begin
                pixel.red   = b0 ^ SIGN_FLIP;
                pixel.green = b1 ^ SIGN_FLIP;
                pixel.blue  = b2 ^ SIGN_FLIP;
                pixel.alpha = CHAN_MAX;
            end
            default: begin
                // unsupported and unassigned codes: zero channels, flag set
                pixel.unsupported = 1'b1;
            end
        endcase
    end

endmodule

[rtl/texel_to_rgba8_converter.sv]
// Top level of the texel to RGBA8 converter: two-stage valid/ready pipeline.
//
// Converts one source texel per transaction into one RGBA8 result, at a
// sustained rate of one texel per clock while m_ready stays high. The
// texel lands in an input register, goes through the format decode, and
// lands in the result register that drives m_valid. s_ready is high
// whenever the input register is empty or moving on, so a new texel is taken
// while a finished result still waits on m_ready; with both registers full
// and m_ready low the block holds s_ready low. source_format is written
// through cfg_we/cfg_wdata and must only change while no texel is in
// flight. Codes 9 through 15 return zero channels with the unsupported flag.
// image_end rides along with its texel unchanged.
module texel_to_rgba8_converter (
    input  logic                    aclk,
    input  logic                    aresetn,
    // source texels
    input  logic                    s_valid,
    output logic                    s_ready,
    input  t2rgba_pkg::t2rgba_in_t  s_data,
    // RGBA8 results
    output logic                    m_valid,
    input  logic                    m_ready,
    output t2rgba_pkg::t2rgba_out_t m_data,
    // format register
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_wdata
);
    import t2rgba_pkg::*;

    logic [3:0]  fmt_reg, fmt_next;
    logic        in_valid_reg, in_valid_next;
    t2rgba_in_t  in_data_reg, in_data_next;
    logic        out_valid_reg, out_valid_next;
    t2rgba_out_t out_data_reg, out_data_next;
    t2rgba_out_t conv_pixel;
    logic        in_advance;
    logic        s_accept;

    // result stage takes a new transaction when empty or being drained
    assign in_advance = !out_valid_reg || m_ready;
    assign s_ready    = !in_valid_reg || in_advance;
    assign s_accept   = s_valid && s_ready;

    t2rgba_convert u_convert (
        .source_format (fmt_reg),
        .texel         (in_data_reg),
        .pixel         (conv_pixel)
    );

    always_comb begin
        fmt_next = cfg_we ? cfg_wdata : fmt_reg;

        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (s_accept) begin
            in_data_next = s_data;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_advance) begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                out_data_next = conv_pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= FMT_RGBA8;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fmt_reg       <= fmt_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[rtl/t2rgba_checker.sv]
// Port-level assertion checker for the texel converter, with its bind.
`include "texel_to_rgba8_converter_defines.svh"

module t2rgba_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input t2rgba_pkg::t2rgba_in_t  s_data,
    input logic                    m_valid,
    input logic                    m_ready,
    input t2rgba_pkg::t2rgba_out_t m_data,
    input logic                    cfg_we
);
    import t2rgba_pkg::*;

    logic s_stall;
    logic m_stall;
    logic unsup_out;
    logic chans_zero;

    assign s_stall    = s_valid && !s_ready;
    assign m_stall    = m_valid && !m_ready;
    assign unsup_out  = m_valid && m_data.unsupported;
    assign chans_zero = ({m_data.red, m_data.green, m_data.blue, m_data.alpha} == 32'h0);

    `T2R_ASSERT(a_m_hold, m_stall |=> m_valid && $stable(m_data), "result moved while stalled")

    `T2R_ASSERT(a_s_hold, s_stall |=> s_valid && $stable(s_data), "texel moved while stalled")

    `T2R_ASSERT_ALWAYS(a_rst_clear, !aresetn |=> !m_valid, "result valid right after reset")

    `T2R_ASSERT(a_unsup_zero, unsup_out |-> chans_zero, "flagged result with nonzero channels")

    `T2R_ASSERT(a_cfg_idle, cfg_we |-> !m_valid && !s_valid, "format write while busy")

endmodule

bind texel_to_rgba8_converter t2rgba_checker u_t2rgba_checker (.*);

[verif/texel_to_rgba8_checker.sv]
// Checker for the texel to RGBA8 converter: tracks the format, predicts each result, compares.
module texel_to_rgba8_checker (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  t2rgba_pkg::t2rgba_in_t  s_data,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  t2rgba_pkg::t2rgba_out_t m_data,
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_wdata,
    output int                      pending_results,
    output int                      checked_results,
    output int                      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import t2rgba_pkg::*;

    logic [3:0]  model_format;
    t2rgba_out_t expected_rgba_q[$];

    // truncating widen of an n-bit channel to eight bits
    function automatic logic [7:0] scale_to_byte(input int unsigned v, input int unsigned vmax);
        return 8'((v * 255) / vmax);
    endfunction

    function automatic t2rgba_out_t convert_texel(input logic [3:0] fmt, input t2rgba_in_t item);
        t2rgba_out_t res;
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] px;
        {b3, b2, b1, b0} = item.texel_word;
        px  = item.texel_word[15:0];
        res = '0;
        res.image_end_out = item.image_end;
        case (fmt)
            FMT_RGBA8, FMT_RAW32: begin
                res.red = b0; res.green = b1; res.blue = b2; res.alpha = b3;
            end
            FMT_BGRA8: begin
                res.red = b2; res.green = b1; res.blue = b0; res.alpha = b3;
            end
            FMT_R8: begin
                res.red = b0; res.green = b0; res.blue = b0; res.alpha = CHAN_MAX;
            end
            FMT_RG8: begin
                res.red = b0; res.green = b1; res.blue = 8'h00; res.alpha = CHAN_MAX;
            end
            FMT_R5G6B5: begin
                res.red   = scale_to_byte(32'(px[15:11]), 31);
                res.green = scale_to_byte(32'(px[10:5]), 63);
                res.blue  = scale_to_byte(32'(px[4:0]), 31);
                res.alpha = CHAN_MAX;
            end
            FMT_A1R5G5B5: begin
                res.red   = scale_to_byte(32'(px[14:10]), 31);
                res.green = scale_to_byte(32'(px[9:5]), 31);
                res.blue  = scale_to_byte(32'(px[4:0]), 31);
                res.alpha = px[15] ? CHAN_MAX : 8'h00;
            end
            FMT_A4R4G4B4: begin
                res.alpha = 8'(int'(px[15:12]) * 17);
                res.red   = 8'(int'(px[11:8]) * 17);
                res.green = 8'(int'(px[7:4]) * 17);
                res.blue  = 8'(int'(px[3:0]) * 17);
            end
            FMT_RGB8_SIGNED: begin
                res.red   = b0 ^ SIGN_FLIP;
                res.green = b1 ^ SIGN_FLIP;
                res.blue  = b2 ^ SIGN_FLIP;
                res.alpha = CHAN_MAX;
            end
            // unsupported code and the unassigned ones above it
            default: res.unsupported = 1'b1;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        t2rgba_out_t want;
        if (!aresetn) begin
            expected_rgba_q.delete();
            model_format    = FMT_RGBA8;
            checked_results = 0;
            fail_count      = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rgba_q.size() == 0) begin
                    $error("result %h with no texel outstanding", m_data);
                    fail_count++;
                end else begin
                    want = expected_rgba_q.pop_front();
                    compare_field("red", want.red, m_data.red);
                    compare_field("green", want.green, m_data.green);
                    compare_field("blue", want.blue, m_data.blue);
                    compare_field("alpha", want.alpha, m_data.alpha);
                    compare_field("unsupported", {7'b0, want.unsupported},
                                  {7'b0, m_data.unsupported});
                    compare_field("image_end_out", {7'b0, want.image_end_out},
                                  {7'b0, m_data.image_end_out});
                    checked_results++;
                end
            end
            if (s_valid && s_ready)
                expected_rgba_q.push_back(convert_texel(model_format, s_data));
            // writes only land while idle, so order against the input is moot
            if (cfg_we)
                model_format = cfg_wdata;
        end
        pending_results <= expected_rgba_q.size();
    end

endmodule

[verif/tb_texel_to_rgba8_converter.sv]
// Testbench top for the texel to RGBA8 converter: stimulus, format phases and verdict.
module tb_texel_to_rgba8_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import t2rgba_pkg::*;

    localparam int CLK_HALF_NS   = 4;     // 8 ns period
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_IDLE      = 10;    // per-transaction gap on either side
    localparam int LONG_HOLD     = 150;   // receiver back-pressure stretch
    localparam int DRAIN_CYCLES  = 6;     // two-stage pipe plus margin
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int RANDOM_PHASES = 16;

    // codes past the named formats; the block must flag them as unsupported
    localparam logic [3:0] FMT_FIRST_UNASSIGNED = 4'd10;
    localparam logic [3:0] FMT_LAST_UNASSIGNED  = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    t2rgba_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    t2rgba_out_t m_data;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;

    int          pending_results;
    int          checked_results;
    int          fail_count;

    bit          idle_on;        // random gaps on both sides when set
    int          texels_sent;
    int          results_taken;
    int          stall_cycles;
    logic [15:0] formats_used;

    initial aclk = 1'b0;
    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    texel_to_rgba8_converter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Watches both channels and the format register, owns the expectation queue.
    texel_to_rgba8_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .checked_results (checked_results),
        .fail_count      (fail_count)
    );

    // Offer one texel; returns at the edge where the transaction is taken.
    // With no gap, valid simply stays high and only the payload changes.
    task automatic send_texel(input logic [31:0] word, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{texel_word: word, image_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        texels_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    // The first edge lets the checker register the last accepted texel.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Format changes only with the pipe empty.
    task automatic set_format(input logic [3:0] code);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        formats_used[code] = 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random ready gaps, plus a few long holds so the block
    // fills both stages and drops s_ready while the sender keeps offering.
    initial begin
        int hold;
        m_ready       = 1'b0;
        results_taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (results_taken == 300 || results_taken == 1000 || results_taken == 1600)
                hold = LONG_HOLD;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_taken++;
        end
    end

    // Watchdog: a hang or a lost result shows up as a long run of idle edges.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("texel_to_rgba8_converter verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [31:0] word;
        logic [3:0]  code;
        int          n_items;
        int          pick;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = FMT_RGBA8;
        idle_on      = 1'b1;
        texels_sent  = 0;
        formats_used = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: reset format first, no register write yet
        formats_used[FMT_RGBA8] = 1'b1;
        send_texel(32'h0000_0000, 1'b0);
        send_texel(32'hFFFF_FFFF, 1'b1);
        send_texel(32'h80FF_7F01, 1'b0);

        // every named format at both corners of the word, image end both ways
        for (int c = int'(FMT_BGRA8); c <= int'(FMT_UNSUPPORTED); c++) begin
            set_format(4'(c));
            send_texel(32'hFFFF_FFFF, 1'b1);
            send_texel(32'h0000_0000, 1'b0);
        end

        // unassigned codes at both ends of their range
        set_format(FMT_FIRST_UNASSIGNED);
        send_texel(32'hA5A5_5A5A, 1'b1);
        set_format(FMT_LAST_UNASSIGNED);
        send_texel(32'h5A5A_A5A5, 1'b0);

        // --- random: one phase per code, stride 7 walks all sixteen codes.
        // Every fourth phase runs with no gaps on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            code = 4'((p * 7) % 16);
            set_format(code);
            idle_on = (p % 4 != 3);
            n_items = $urandom_range(80, 145);
            repeat (n_items) begin
                word = $urandom();
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    word = '0;
                else if (pick == 1)
                    word = '1;
                send_texel(word, $urandom_range(0, 7) == 0);
            end
        end

        wait_for_drain();

        $display("%0d texels sent, %0d results checked, %0d of 16 format codes exercised",
                 texels_sent, checked_results, $countones(formats_used));
        $display("both sides ran random gaps, gap-free phases and long result stalls");
        if (fail_count == 0)
            $display("texel_to_rgba8_converter verification clean");
        else
            $display("texel_to_rgba8_converter verification failed");
        $finish;
    end

endmodule
